// ===== design/jqse_pkg.sv =====
// Shared types and constants for the job queue with search and erase.
package jqse_pkg;

  // Default queue depth
  localparam int DEPTH_DEF = 16;

  localparam int ID_W  = 16;
  localparam int CNT_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_ERASE = 2'd2,
    OP_FIND  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Input word
  typedef struct packed {
    op_t              opcode;
    logic [ID_W-1:0]  job_id;
    logic [CNT_W-1:0] position;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [ID_W-1:0]  head_id;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] found_position;
    status_t          status;
  } out_word_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic load;    // take the pushed id
    logic shift;   // take the neighbor's id (gap closing)
    logic cmp;     // latch compare result for find
    logic occ;     // slot holds a queued job
  } cell_ctrl_t;

endpackage

// ===== design/jqse_cell.sv =====
// One queue slot: holds an id, shifts from its neighbor, compares for find.
module jqse_cell
  import jqse_pkg::*;
(
  input  logic            clk,
  input  cell_ctrl_t      ctrl,
  input  logic [ID_W-1:0] push_id,
  input  logic [ID_W-1:0] nbr_id,
  input  logic [ID_W-1:0] cmp_id,
  output logic [ID_W-1:0] slot_id,
  output logic            match
);

  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] id_nxt;
  logic            match_r;

  // slot update: shift has priority, a push never coincides with a shift
  always_comb begin
    id_nxt = id_r;
    priority if (ctrl.shift) begin
      id_nxt = nbr_id;
    end else if (ctrl.load) begin
      id_nxt = push_id;
    end
  end

  // slot and match registers (payload only)
  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    if (ctrl.cmp) begin
      match_r <= ctrl.occ && (id_r == cmp_id);
    end
  end

  assign slot_id = id_r;
  assign match   = match_r;

endmodule

// ===== design/jqse_first_match.sv =====
// First-match encoder over the cells' match flags, 1-based, 0 when none.
module jqse_first_match
  import jqse_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic [DEPTH-1:0] match,
  output logic [CNT_W-1:0] found_pos
);

  // scan from the tail so the lowest matching slot wins
  always_comb begin
    found_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_pos = CNT_W'(i + 1);
      end
    end
  end

endmodule

// ===== design/job_queue_search_erase.sv =====
// Top level: job queue controller, chain of slot cells and result register.
// Ordered queue of up to DEPTH 16-bit job ids, held in a row of cells with the
// head in cell 0. Push, pop and erase update the cells straight from the accepted
// word: every cell decides locally whether to load the pushed id or take its
// neighbor's id, so a whole gap closes in a single shift. For a find, the cells
// first compare and latch a match flag, then a first-match encoder over those flags
// produces the position; no new word is taken while the find is in progress. Each word yields one
// result word, held in an output register so the next word can be accepted
// while a result is waiting, as long as that result is taken in the same cycle.
// Errors (push when full, pop when empty, erase position out of range) leave
// the queue unchanged and are reported in the status field.
module job_queue_search_erase
  import jqse_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int WW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic {
    S_RUN,
    S_FIND
  } state_t;

  state_t          state_r;
  state_t          state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  out_word_t       out_data_r;
  out_word_t       out_data_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  logic            accept;
  logic            do_push;
  logic            do_rm;
  logic            do_find;
  logic [IW-1:0]   rm_idx;
  status_t         status;
  logic [WW-1:0]   pos_w;
  logic [WW-1:0]   cnt_w;
  logic [ID_W-1:0] head_nxt;
  logic [CNT_W-1:0] found_pos;

  cell_ctrl_t      ctrl   [DEPTH];
  logic [ID_W-1:0] slot   [DEPTH];
  logic [ID_W-1:0] nbr    [DEPTH];
  logic [DEPTH-1:0] match;

  // handshake
  assign in_ready = (state_r == S_RUN) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // opcode decode and range checks
  assign pos_w = WW'(in_data.position);
  assign cnt_w = WW'(count_r);

  always_comb begin
    do_push = 1'b0;
    do_rm   = 1'b0;
    do_find = 1'b0;
    rm_idx  = '0;
    status  = ST_OK;
    unique case (in_data.opcode)
      OP_PUSH: begin
        if (count_r == CW'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          do_push = accept;
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          do_rm = accept;
        end
      end
      OP_ERASE: begin
        if (pos_w == '0 || pos_w > cnt_w) begin
          status = ST_BADPOS;
        end else begin
          do_rm  = accept;
          rm_idx = IW'(pos_w - WW'(1));
        end
      end
      OP_FIND: begin
        do_find = accept;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // count update
  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rm) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i] = slot[i + 1];
    end

    assign ctrl[i].load  = do_push && (count_r == CW'(i));
    assign ctrl[i].shift = do_rm && (IW'(i) >= rm_idx);
    assign ctrl[i].cmp   = do_find;
    assign ctrl[i].occ   = CW'(i) < count_r;

    jqse_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl[i]),
      .push_id (in_data.job_id),
      .nbr_id  (nbr[i]),
      .cmp_id  (in_data.job_id),
      .slot_id (slot[i]),
      .match   (match[i])
    );
  end

  jqse_first_match #(
    .DEPTH (DEPTH)
  ) u_first_match (
    .match     (match),
    .found_pos (found_pos)
  );

  // head after this word
  always_comb begin
    if (count_nxt == '0) begin
      head_nxt = '0;
    end else if (do_rm && rm_idx == '0) begin
      head_nxt = slot[1];
    end else if (do_push && count_r == '0) begin
      head_nxt = in_data.job_id;
    end else begin
      head_nxt = slot[0];
    end
  end

  // next state and result word
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_RUN: begin
        if (accept) begin
          if (in_data.opcode == OP_FIND) begin
            state_nxt = S_FIND;
          end else begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.head_id        = head_nxt;
            out_data_nxt.entry_count    = CNT_W'(count_nxt);
            out_data_nxt.found_position = '0;
            out_data_nxt.status         = status;
          end
        end
      end
      S_FIND: begin
        state_nxt                   = S_RUN;
        out_valid_nxt               = 1'b1;
        out_data_nxt.head_id        = (count_r == '0) ? '0 : slot[0];
        out_data_nxt.entry_count    = CNT_W'(count_r);
        out_data_nxt.found_position = found_pos;
        out_data_nxt.status         = ST_OK;
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  // state, count and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      count_r     <= count_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a find in progress always has a free result register
  a_find_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> !out_valid_r)
    else $error("find stage entered with result register occupied");

  // a find always completes with a result in the next cycle
  a_find_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |=> (out_valid_r && state_r == S_RUN))
    else $error("find did not deliver a result");

  // a good push grows the queue by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.opcode == OP_PUSH && count_r != CW'(DEPTH))
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the queue");

  // count never exceeds the depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule
